// ===== sv/code_correlator_iq_top_defines.svh =====
// Assertion macros shared by the code correlator RTL.
`ifndef CODE_CORRELATOR_IQ_TOP_DEFINES_SVH
`define CODE_CORRELATOR_IQ_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CCI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define CCI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define CCI_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define CCI_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/cci_pkg.sv =====
// Shared types and constants for the code correlator.
package cci_pkg;

  localparam int unsigned FRAC_BITS   = 20;
  localparam int unsigned ACC_W       = 29;
  localparam int unsigned STEP_W      = 24;
  localparam int unsigned REM_W       = 20;
  localparam int unsigned SPACING_W   = 22;
  localparam int unsigned DUMP_W      = 13;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned ADDR_IN_W   = 11;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [STEP_W-1:0]           STEP_RST    = 24'd107269;
  localparam logic [REM_W-1:0]            REM_RST     = 20'd0;
  localparam logic signed [SPACING_W-1:0] SPACING_RST = 22'sd524288;
  localparam logic [DUMP_W-1:0]           DUMP_RST    = 13'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_STEP    = 2'd0,
    REG_REM_PHASE    = 2'd1,
    REG_SPACING      = 2'd2,
    REG_DUMP_LENGTH  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // Control part of one queued command
  typedef struct packed {
    logic is_sample;
    logic ok;      // load: address in range; sample: index in table
    logic last;    // sample closes the dump
    logic chip;    // load value
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic busy;    // read stage holds a sample
  } back_stat_t;

endpackage

// ===== sv/code_correlator_iq_top.sv =====
// Spreading-code correlator, one tap, I and Q: top level.
// Throughput: one item per cycle, load or sample, while the queue is not full (a stalled result can fill it).
// m_axis_tvalid rises once a dump's closing sample has passed the queue write on the accepting edge,
// the code table read and the result register; a stall on the result output delays it.
// Reset clears phase, count, sums, queue and result valid, and reloads config defaults;
// the code table is not cleared and must be loaded before use.
`include "code_correlator_iq_top_defines.svh"

module code_correlator_iq_top #(
  parameter int unsigned CODE_DEPTH  = 2048,
  parameter int unsigned MAX_DUMP    = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cci_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cci_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // chip_address, chip_value, i_sample, q_sample (low bits up), zero padded
  input  logic [((12+2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // op
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // i_corr, q_corr (low bits up), zero padded
  output logic [cci_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // index_fault
  output logic                                 m_axis_tuser
);

  localparam int unsigned ADDR_W = $clog2(CODE_DEPTH);
  localparam int unsigned CMD_W  = $bits(cci_pkg::cmd_t);
  localparam int unsigned Q_W    = CMD_W + ADDR_W + 2 * SAMPLE_BITS;
  localparam int unsigned I_LO   = cci_pkg::ADDR_IN_W + 1;

  cci_pkg::q_stat_t              q_stat;
  cci_pkg::back_stat_t           b_stat;
  cci_pkg::cmd_t                 f_cmd, b_cmd;
  logic [ADDR_W-1:0]             f_addr, b_addr;
  logic                          f_push;
  logic signed [SAMPLE_BITS-1:0] in_i, in_q, b_i, b_q;
  logic [Q_W-1:0]                push_data, pop_data;
  logic signed [cci_pkg::ACC_W-1:0] i_corr, q_corr;

  assign in_i = s_axis_tdata[I_LO +: SAMPLE_BITS];
  assign in_q = s_axis_tdata[I_LO + SAMPLE_BITS +: SAMPLE_BITS];

  cci_front #(
    .CODE_DEPTH  (CODE_DEPTH),
    .MAX_DUMP    (MAX_DUMP)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .op_i           (s_axis_tuser),
    .chip_address_i (s_axis_tdata[cci_pkg::ADDR_IN_W-1:0]),
    .chip_value_i   (s_axis_tdata[cci_pkg::ADDR_IN_W]),
    .q_stat_i       (q_stat),
    .push_o         (f_push),
    .cmd_o          (f_cmd),
    .addr_o         (f_addr)
  );

  assign push_data = {in_q, in_i, f_addr, f_cmd};

  cci_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_push),
    .push_data_i (push_data),
    .pop_i       (b_stat.pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  assign {b_q, b_i, b_addr, b_cmd} = pop_data;

  cci_back #(
    .CODE_DEPTH  (CODE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .cmd_i         (b_cmd),
    .addr_i        (b_addr),
    .i_sample_i    (b_i),
    .q_sample_i    (b_q),
    .stat_o        (b_stat),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .i_corr_o      (i_corr),
    .q_corr_o      (q_corr),
    .index_fault_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{(cci_pkg::OUT_TDATA_W - 2 * cci_pkg::ACC_W){1'b0}}, q_corr, i_corr};

  `CCI_ASSERT_IMP(a_queue_flags, clk_i, rst_ni, 1'b1, !(q_stat.full && q_stat.empty))
  `CCI_ASSERT_NXT(a_full_blocks_input, clk_i, rst_ni, q_stat.full && !b_stat.pop, !s_axis_tready)
  `CCI_ASSERT_IMP(a_result_from_stage, clk_i, rst_ni, $rose(m_axis_tvalid), $past(b_stat.busy))

endmodule

// ===== sv/cci_ram.sv =====
// Generic single-port RAM with registered read.
module cci_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cci_queue.sv =====
// Short FIFO between the front and back halves.
module cci_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     push_data_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     pop_data_o,
  output cci_pkg::q_stat_t     stat_o
);

  logic [WIDTH-1:0]            slot_q [cci_pkg::QUEUE_DEPTH];
  logic [cci_pkg::QPTR_W-1:0]  wptr_q, wptr_d;
  logic [cci_pkg::QPTR_W-1:0]  rptr_q, rptr_d;
  logic [cci_pkg::QCNT_W-1:0]  cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign stat_o.full  = (cnt_q == cci_pkg::QCNT_W'(cci_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign pop_data_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/cci_front.sv =====
// Front half: config registers, code phase tracking, chip index and dump count.
module cci_front #(
  parameter int unsigned CODE_DEPTH  = 2048,
  parameter int unsigned MAX_DUMP    = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [cci_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [cci_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  op_i,
  input  logic [cci_pkg::ADDR_IN_W-1:0]         chip_address_i,
  input  logic                                  chip_value_i,
  input  cci_pkg::q_stat_t                      q_stat_i,
  output logic                                  push_o,
  output cci_pkg::cmd_t                         cmd_o,
  output logic [$clog2(CODE_DEPTH)-1:0]         addr_o
);

  localparam int unsigned ADDR_W  = $clog2(CODE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(MAX_DUMP + 1);
  localparam int unsigned LEN_W   = (CNT_W > cci_pkg::DUMP_W) ? CNT_W : cci_pkg::DUMP_W;
  localparam int unsigned PHASE_W = cci_pkg::STEP_W + CNT_W + 2;
  localparam int unsigned UPPER_W = PHASE_W - cci_pkg::FRAC_BITS;
  localparam logic signed [PHASE_W-1:0] ROUND_UP = PHASE_W'((1 << cci_pkg::FRAC_BITS) - 1);

  logic [cci_pkg::STEP_W-1:0]           step_q;
  logic [cci_pkg::REM_W-1:0]            rem_q;
  logic signed [cci_pkg::SPACING_W-1:0] spacing_q;
  logic [cci_pkg::DUMP_W-1:0]           dump_q;

  logic signed [PHASE_W-1:0] phase_q, phase_d;
  logic [CNT_W-1:0]          count_q, count_d;

  logic signed [PHASE_W-1:0] start_phase, cur_phase, ceil_sum;
  logic [LEN_W-1:0]          len_raw, len_eff, cnt_inc;
  logic                      accept, is_sample, idx_ok, last;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign is_sample  = (op_i == cci_pkg::OP_SAMPLE);

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= cci_pkg::STEP_RST;
      rem_q     <= cci_pkg::REM_RST;
      spacing_q <= cci_pkg::SPACING_RST;
      dump_q    <= cci_pkg::DUMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cci_pkg::REG_CODE_STEP:   step_q    <= cfg_data_i[cci_pkg::STEP_W-1:0];
        cci_pkg::REG_REM_PHASE:   rem_q     <= cfg_data_i[cci_pkg::REM_W-1:0];
        cci_pkg::REG_SPACING:     spacing_q <= cfg_data_i[cci_pkg::SPACING_W-1:0];
        cci_pkg::REG_DUMP_LENGTH: dump_q    <= cfg_data_i[cci_pkg::DUMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    start_phase = $signed({{(PHASE_W-cci_pkg::REM_W){1'b0}}, rem_q}) + PHASE_W'(spacing_q);
    cur_phase   = (count_q == '0) ? start_phase : phase_q;
    // ceil(phase) in whole chips; non-negative sum means phase > -1 chip
    ceil_sum    = cur_phase + ROUND_UP;
    idx_ok      = !ceil_sum[PHASE_W-1] &&
                  (ceil_sum[PHASE_W-1:cci_pkg::FRAC_BITS] < UPPER_W'(CODE_DEPTH));

    len_raw = LEN_W'(dump_q);
    if (len_raw == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_raw > LEN_W'(MAX_DUMP)) begin
      len_eff = LEN_W'(MAX_DUMP);
    end else begin
      len_eff = len_raw;
    end
    cnt_inc = LEN_W'(count_q) + LEN_W'(1);
    last    = (cnt_inc >= len_eff);

    count_d = count_q;
    phase_d = phase_q;
    if (accept && is_sample) begin
      count_d = last ? '0 : CNT_W'(cnt_inc);
      phase_d = last ? '0 : cur_phase + $signed({{(PHASE_W-cci_pkg::STEP_W){1'b0}}, step_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    push_o          = accept;
    cmd_o.is_sample = is_sample;
    cmd_o.ok        = is_sample ? idx_ok
                                : (32'(chip_address_i) < 32'(CODE_DEPTH));
    cmd_o.last      = is_sample && last;
    cmd_o.chip      = chip_value_i;
    addr_o          = is_sample ? ADDR_W'(ceil_sum[PHASE_W-1:cci_pkg::FRAC_BITS])
                                : ADDR_W'(chip_address_i);
  end

endmodule

// ===== sv/cci_back.sv =====
// Back half: code table, chip read, I/Q accumulation and result register.
module cci_back #(
  parameter int unsigned CODE_DEPTH  = 2048,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cci_pkg::q_stat_t                      q_stat_i,
  input  cci_pkg::cmd_t                         cmd_i,
  input  logic [$clog2(CODE_DEPTH)-1:0]         addr_i,
  input  logic signed [SAMPLE_BITS-1:0]         i_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]         q_sample_i,
  output cci_pkg::back_stat_t                   stat_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [cci_pkg::ACC_W-1:0]      i_corr_o,
  output logic signed [cci_pkg::ACC_W-1:0]      q_corr_o,
  output logic                                  index_fault_o
);

  localparam int unsigned ACC_W = cci_pkg::ACC_W;

  logic                         pop, s1_ready, s1_adv, chip;
  logic                         ram_en;
  logic                         ram_rdata;
  logic                         s1_valid_q, s1_ok_q, s1_last_q;
  logic signed [SAMPLE_BITS-1:0] s1_i_q, s1_q_q;
  logic signed [ACC_W-1:0]      acc_i_q, acc_q_q, acc_i_new, acc_q_new, i_ext, q_ext;
  logic                         fault_q, fault_new;
  logic                         out_valid_q, out_valid_d;
  logic signed [ACC_W-1:0]      out_i_q, out_q_q;
  logic                         out_fault_q;

  assign s1_adv   = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign s1_ready = !s1_valid_q || s1_adv;
  assign pop      = !q_stat_i.empty && s1_ready;
  assign ram_en   = pop && cmd_i.ok;

  assign stat_o.pop  = pop;
  assign stat_o.busy = s1_valid_q;

  cci_ram #(
    .WIDTH (1),
    .DEPTH (CODE_DEPTH)
  ) u_code_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (!cmd_i.is_sample),
    .addr_i  (addr_i),
    .wdata_i (cmd_i.chip),
    .rdata_o (ram_rdata)
  );

  // Read stage: chip comes out of the RAM in the cycle after the pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= pop && cmd_i.is_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_ok_q   <= cmd_i.ok;
      s1_last_q <= cmd_i.last;
      s1_i_q    <= i_sample_i;
      s1_q_q    <= q_sample_i;
    end
  end

  always_comb begin
    chip      = ram_rdata;
    i_ext     = ACC_W'(s1_i_q);
    q_ext     = ACC_W'(s1_q_q);
    acc_i_new = acc_i_q;
    acc_q_new = acc_q_q;
    if (s1_ok_q) begin
      acc_i_new = chip ? acc_i_q + i_ext : acc_i_q - i_ext;
      acc_q_new = chip ? acc_q_q + q_ext : acc_q_q - q_ext;
    end
    fault_new = fault_q || !s1_ok_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
      fault_q <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        acc_i_q <= '0;
        acc_q_q <= '0;
        fault_q <= 1'b0;
      end else begin
        acc_i_q <= acc_i_new;
        acc_q_q <= acc_q_new;
        fault_q <= fault_new;
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (s1_adv && s1_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_i_q     <= acc_i_new;
      out_q_q     <= acc_q_new;
      out_fault_q <= fault_new;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign i_corr_o      = out_i_q;
  assign q_corr_o      = out_q_q;
  assign index_fault_o = out_fault_q;

endmodule
